FILE: src/akrc_pkg.sv
package akrc_pkg;

    // Table geometry and field widths.
    localparam int MaxEntriesDefault = 16;
    localparam int KeyW  = 52;
    localparam int TtlW  = 16;
    localparam int WordW = KeyW + TtlW;

    // Register reset values.
    localparam logic [15:0] TimeoutReset   = 16'd120;
    localparam logic [4:0]  MaxCachedReset = 5'd10;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_TIMEOUT    = 2'd0;
    localparam logic [1:0] CFG_MAX_CACHED = 2'd1;

    // Function codes of an input word.
    localparam logic [2:0] FUNC_REPORT    = 3'd0;
    localparam logic [2:0] FUNC_TICK      = 3'd1;
    localparam logic [2:0] FUNC_CLEAR_MSK = 3'd2;
    localparam logic [2:0] FUNC_COLLECT   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR_ALL = 3'd4;

    // Status codes of a result word.
    localparam logic [1:0] STAT_INSERTED  = 2'd0;
    localparam logic [1:0] STAT_REFRESHED = 2'd1;
    localparam logic [1:0] STAT_DROPPED   = 2'd2;
    localparam logic [1:0] STAT_OTHER     = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FIN
    } t_state;

endpackage

FILE: src/akrc_mem.sv
module akrc_mem #(
    parameter int DEPTH = akrc_pkg::MaxEntriesDefault,
    parameter int WIDTH = akrc_pkg::WordW,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/akrc_ctrl.sv
module akrc_ctrl #(
    parameter int MAX_ENTRIES = akrc_pkg::MaxEntriesDefault,
    parameter int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2:0]                i_func,
    input  logic [akrc_pkg::KeyW-1:0] i_key,
    input  logic [15:0]               i_timeout,
    input  logic [4:0]                i_max_cached,
    output logic                      o_busy,
    // Memory side
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [akrc_pkg::WordW-1:0] o_wdata,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    input  logic [akrc_pkg::WordW-1:0] i_rdata,
    // Result word
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic                      o_list_changed,
    output logic [4:0]                o_entry_count,
    output logic                      o_entry_valid,
    output logic [akrc_pkg::KeyW-1:0] o_key,
    output logic                      o_last
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] NEnt = CW'(MAX_ENTRIES);
    localparam int KW = akrc_pkg::KeyW;
    localparam int TW = akrc_pkg::TtlW;

    akrc_pkg::t_state r_state, n_state;
    logic [2:0]             r_func, n_func;
    logic [KW-1:0]          r_key, n_key;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_slot, n_slot;
    logic [MAX_ENTRIES-1:0] r_vld, n_vld;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_hit, n_hit;
    logic [AW-1:0]          r_hit_slot, n_hit_slot;
    logic                   r_free_found, n_free_found;
    logic [AW-1:0]          r_free_slot, n_free_slot;
    logic                   r_changed, n_changed;
    logic [KW-1:0]          r_prev, n_prev;
    logic                   r_have_prev, n_have_prev;
    logic [KW-1:0]          r_best, n_best;
    logic                   r_best_found, n_best_found;
    logic [CW-1:0]          r_emitted, n_emitted;
    logic                   r_o_valid, n_o_valid;
    logic [1:0]             r_o_status, n_o_status;
    logic                   r_o_changed, n_o_changed;
    logic                   r_o_entry_valid, n_o_entry_valid;
    logic [KW-1:0]          r_o_key, n_o_key;
    logic                   r_o_last, n_o_last;

    logic            accept;
    logic            sweep_done;
    logic            fin_more;
    logic            table_full;
    logic [KW-1:0]   rd_key;
    logic [TW-1:0]   rd_ttl;
    logic [CW-1:0]   emitted_inc;

    assign accept      = i_start && (r_state == akrc_pkg::ST_IDLE);
    assign sweep_done  = (r_idx == NEnt);
    assign rd_key      = i_rdata[akrc_pkg::WordW-1:TW];
    assign rd_ttl      = i_rdata[TW-1:0];
    assign emitted_inc = r_emitted + CW'(1);
    assign fin_more    = (r_func == akrc_pkg::FUNC_COLLECT) && (r_count != '0)
                         && (emitted_inc != r_count);
    assign table_full  = (CMPW'(r_count) >= CMPW'(i_max_cached)) || !r_free_found;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            akrc_pkg::ST_IDLE: begin
                if (accept && (i_func == akrc_pkg::FUNC_REPORT ||
                               i_func == akrc_pkg::FUNC_TICK ||
                               i_func == akrc_pkg::FUNC_CLEAR_MSK ||
                               i_func == akrc_pkg::FUNC_COLLECT)) begin
                    n_state = akrc_pkg::ST_SWEEP;
                end
            end
            akrc_pkg::ST_SWEEP: begin
                if (sweep_done) begin
                    n_state = akrc_pkg::ST_FIN;
                end
            end
            akrc_pkg::ST_FIN: begin
                n_state = fin_more ? akrc_pkg::ST_SWEEP : akrc_pkg::ST_IDLE;
            end
            default: n_state = akrc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        n_func          = r_func;
        n_key           = r_key;
        n_idx           = r_idx;
        n_pend          = 1'b0;
        n_slot          = r_slot;
        n_vld           = r_vld;
        n_count         = r_count;
        n_hit           = r_hit;
        n_hit_slot      = r_hit_slot;
        n_free_found    = r_free_found;
        n_free_slot     = r_free_slot;
        n_changed       = r_changed;
        n_prev          = r_prev;
        n_have_prev     = r_have_prev;
        n_best          = r_best;
        n_best_found    = r_best_found;
        n_emitted       = r_emitted;
        n_o_valid       = 1'b0;
        n_o_status      = r_o_status;
        n_o_changed     = r_o_changed;
        n_o_entry_valid = r_o_entry_valid;
        n_o_key         = r_o_key;
        n_o_last        = r_o_last;
        o_we            = 1'b0;
        o_waddr         = r_slot;
        o_wdata         = i_rdata;
        o_re            = 1'b0;
        o_raddr         = r_idx[AW-1:0];

        case (r_state)
            akrc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func       = i_func;
                    n_key        = i_key;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_changed    = 1'b0;
                    n_have_prev  = 1'b0;
                    n_best_found = 1'b0;
                    n_emitted    = '0;
                    // Clear all and unused codes finish at once.
                    if (i_func == akrc_pkg::FUNC_CLEAR_ALL) begin
                        n_vld   = '0;
                        n_count = '0;
                    end
                    if (i_func != akrc_pkg::FUNC_REPORT && i_func != akrc_pkg::FUNC_TICK &&
                        i_func != akrc_pkg::FUNC_CLEAR_MSK &&
                        i_func != akrc_pkg::FUNC_COLLECT) begin
                        n_o_valid       = 1'b1;
                        n_o_status      = akrc_pkg::STAT_OTHER;
                        n_o_changed     = (i_func == akrc_pkg::FUNC_CLEAR_ALL) &&
                                          (r_count != '0);
                        n_o_entry_valid = 1'b0;
                        n_o_key         = '0;
                        n_o_last        = 1'b1;
                    end
                end
            end
            akrc_pkg::ST_SWEEP: begin
                // Issue one read per cycle over every slot.
                if (!sweep_done) begin
                    o_re   = 1'b1;
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                    n_slot = r_idx[AW-1:0];
                end
            end
            akrc_pkg::ST_FIN: begin
                n_o_valid       = 1'b1;
                n_o_entry_valid = 1'b0;
                n_o_key         = '0;
                n_o_last        = 1'b1;
                n_o_changed     = r_changed;
                n_o_status      = akrc_pkg::STAT_OTHER;
                case (r_func)
                    akrc_pkg::FUNC_REPORT: begin
                        n_o_changed = 1'b0;
                        if (r_hit) begin
                            o_we       = 1'b1;
                            o_waddr    = r_hit_slot;
                            o_wdata    = {r_key, i_timeout};
                            n_o_status = akrc_pkg::STAT_REFRESHED;
                        end else if (table_full) begin
                            n_o_status = akrc_pkg::STAT_DROPPED;
                        end else begin
                            o_we               = 1'b1;
                            o_waddr            = r_free_slot;
                            o_wdata            = {r_key, i_timeout};
                            n_vld[r_free_slot] = 1'b1;
                            n_count            = r_count + CW'(1);
                            n_o_status         = akrc_pkg::STAT_INSERTED;
                            n_o_changed        = 1'b1;
                        end
                    end
                    akrc_pkg::FUNC_COLLECT: begin
                        n_o_changed = 1'b0;
                        if (r_count != '0) begin
                            n_o_entry_valid = 1'b1;
                            n_o_key         = r_best;
                            n_o_last        = !fin_more;
                            n_emitted       = emitted_inc;
                            n_prev          = r_best;
                            n_have_prev     = 1'b1;
                            n_best_found    = 1'b0;
                            n_idx           = '0;
                        end
                    end
                    default: begin
                        n_o_status = akrc_pkg::STAT_OTHER;
                    end
                endcase
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase

        // Work on the slot whose read data has just arrived.
        if (r_pend) begin
            case (r_func)
                akrc_pkg::FUNC_REPORT: begin
                    if (r_vld[r_slot] && rd_key == r_key) begin
                        n_hit      = 1'b1;
                        n_hit_slot = r_slot;
                    end
                    if (!r_vld[r_slot] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_slot  = r_slot;
                    end
                end
                akrc_pkg::FUNC_TICK: begin
                    if (r_vld[r_slot]) begin
                        if (rd_ttl <= TW'(1)) begin
                            n_vld[r_slot] = 1'b0;
                            n_count       = r_count - CW'(1);
                            n_changed     = 1'b1;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_slot;
                            o_wdata = {rd_key, rd_ttl - TW'(1)};
                        end
                    end
                end
                akrc_pkg::FUNC_CLEAR_MSK: begin
                    if (r_vld[r_slot] && ((rd_key[KW-1 -: 8] & r_key[KW-1 -: 8]) != '0)) begin
                        n_vld[r_slot] = 1'b0;
                        n_count       = r_count - CW'(1);
                        n_changed     = 1'b1;
                    end
                end
                akrc_pkg::FUNC_COLLECT: begin
                    // Smallest key above the one last emitted.
                    if (r_vld[r_slot] && (!r_have_prev || rd_key > r_prev) &&
                        (!r_best_found || rd_key < r_best)) begin
                        n_best       = rd_key;
                        n_best_found = 1'b1;
                    end
                end
                default: begin
                    n_best = r_best;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= akrc_pkg::ST_IDLE;
            r_pend    <= 1'b0;
            r_vld     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_vld     <= n_vld;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload and tracking registers.
    always_ff @(posedge i_clk) begin
        r_func          <= n_func;
        r_key           <= n_key;
        r_idx           <= n_idx;
        r_slot          <= n_slot;
        r_hit           <= n_hit;
        r_hit_slot      <= n_hit_slot;
        r_free_found    <= n_free_found;
        r_free_slot     <= n_free_slot;
        r_changed       <= n_changed;
        r_prev          <= n_prev;
        r_have_prev     <= n_have_prev;
        r_best          <= n_best;
        r_best_found    <= n_best_found;
        r_emitted       <= n_emitted;
        r_o_status      <= n_o_status;
        r_o_changed     <= n_o_changed;
        r_o_entry_valid <= n_o_entry_valid;
        r_o_key         <= n_o_key;
        r_o_last        <= n_o_last;
    end

    assign o_busy         = (r_state != akrc_pkg::ST_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_list_changed = r_o_changed;
    assign o_entry_count  = 5'(r_count);
    assign o_entry_valid  = r_o_entry_valid;
    assign o_key          = r_o_key;
    assign o_last         = r_o_last;

    // The count register tracks the valid bits.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == 32'(r_count))
        else $error("entry count disagrees with valid bits");

    // No read is outstanding once the sequencer is idle.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == akrc_pkg::ST_IDLE) |-> !r_pend)
        else $error("read data pending while idle");

    // Only collect results carry an entry, always with status other.
    a_entry_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_entry_valid) |-> (r_o_status == akrc_pkg::STAT_OTHER))
        else $error("entry word with wrong status");

    // A result that is not the last one leads straight into another sweep.
    a_not_last_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> (r_state == akrc_pkg::ST_SWEEP))
        else $error("unfinished collect stopped");

endmodule

FILE: src/aging_keyed_result_cache.sv
// Aging table of up to MAX_ENTRIES device keys (transport, discriminator,
// vendor, product), each with a lifetime counted in one-second ticks.
// Input: a word is taken at a clock edge where i_start is high and o_busy is
// low. i_func selects report, tick, clear by transport mask, collect or clear
// all. Configuration must be written via i_cfg_we/i_cfg_index/i_cfg_data
// while idle (the block does not check); index 0 = lifetime, 1 = entry limit.
// Output: each result word is shown for one cycle with o_valid high; the
// receiver cannot stall, so every word must be taken as it appears.
// Timing: keys and lifetimes sit in one synchronous RAM swept one slot per
// cycle. Report, tick and mask clear stay busy through one full sweep and a
// finish step, and give their result in the first cycle with busy low.
// Collect makes one full sweep per emitted entry, in ascending key order.
// Clear all and unused codes answer in the next cycle without going busy.
// A new word can be taken while a word with o_last high is shown.
// Reset: the valid bits and count clear at once; lifetime returns to 120 and
// the entry limit to 10. The RAM is not cleared.
module aging_keyed_result_cache #(
    parameter int MAX_ENTRIES = akrc_pkg::MaxEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_transport,
    input  logic [11:0] i_discriminator,
    input  logic [15:0] i_vendor_id,
    input  logic [15:0] i_product_id,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_list_changed,
    output logic [4:0]  o_entry_count,
    output logic        o_entry_valid,
    output logic [7:0]  o_out_transport,
    output logic [11:0] o_out_discriminator,
    output logic [15:0] o_out_vendor_id,
    output logic [15:0] o_out_product_id,
    output logic        o_last
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [15:0] r_timeout;
    logic [4:0]  r_max_cached;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [akrc_pkg::WordW-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [akrc_pkg::WordW-1:0] mem_rdata;
    logic [akrc_pkg::KeyW-1:0]  out_key;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= akrc_pkg::TimeoutReset;
            r_max_cached <= akrc_pkg::MaxCachedReset;
        end else if (i_cfg_we) begin
            if (i_cfg_index == akrc_pkg::CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end else if (i_cfg_index == akrc_pkg::CFG_MAX_CACHED) begin
                r_max_cached <= i_cfg_data[4:0];
            end
        end
    end

    akrc_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_func         (i_func),
        .i_key          ({i_transport, i_discriminator, i_vendor_id, i_product_id}),
        .i_timeout      (r_timeout),
        .i_max_cached   (r_max_cached),
        .o_busy         (o_busy),
        .o_we           (mem_we),
        .o_waddr        (mem_waddr),
        .o_wdata        (mem_wdata),
        .o_re           (mem_re),
        .o_raddr        (mem_raddr),
        .i_rdata        (mem_rdata),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_list_changed (o_list_changed),
        .o_entry_count  (o_entry_count),
        .o_entry_valid  (o_entry_valid),
        .o_key          (out_key),
        .o_last         (o_last)
    );

    akrc_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (akrc_pkg::WordW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_transport     = out_key[51:44];
    assign o_out_discriminator = out_key[43:32];
    assign o_out_vendor_id     = out_key[31:16];
    assign o_out_product_id    = out_key[15:0];

endmodule

FILE: dv/tb_aging_keyed_result_cache.sv
`timescale 1ns / 100ps

// One result word as seen on the output ports.
typedef struct packed {
    logic [1:0]  status;
    logic        changed;
    logic [4:0]  count;
    logic        ent_valid;
    logic [7:0]  tr;
    logic [11:0] disc;
    logic [15:0] vid;
    logic [15:0] pid;
    logic        last;
} t_word;

// Expected result words, held in order, with a field by field check.
class cache_scoreboard;
    t_word pending[$];
    int    errors;
    int    checked;

    // Append one expected word at the tail of the queue.
    function void append_word(t_word w);
        pending = {pending, w};
    endfunction

    // Note the words that one accepted input will cause.
    function void note_input(t_word words[$]);
        foreach (words[k]) append_word(words[k]);
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_word(t_word got);
        t_word exp_w;
        if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        checked++;
        if (got.status !== exp_w.status) begin
            $error("status exp %0d got %0d", exp_w.status, got.status); errors++;
        end
        if (got.changed !== exp_w.changed) begin
            $error("list_changed exp %0d got %0d", exp_w.changed, got.changed); errors++;
        end
        if (got.count !== exp_w.count) begin
            $error("entry_count exp %0d got %0d", exp_w.count, got.count); errors++;
        end
        if (got.ent_valid !== exp_w.ent_valid) begin
            $error("entry_valid exp %0d got %0d", exp_w.ent_valid, got.ent_valid); errors++;
        end
        if (got.tr !== exp_w.tr) begin
            $error("out_transport exp %0h got %0h", exp_w.tr, got.tr); errors++;
        end
        if (got.disc !== exp_w.disc) begin
            $error("out_discriminator exp %0h got %0h", exp_w.disc, got.disc); errors++;
        end
        if (got.vid !== exp_w.vid) begin
            $error("out_vendor_id exp %0h got %0h", exp_w.vid, got.vid); errors++;
        end
        if (got.pid !== exp_w.pid) begin
            $error("out_product_id exp %0h got %0h", exp_w.pid, got.pid); errors++;
        end
        if (got.last !== exp_w.last) begin
            $error("last exp %0d got %0d", exp_w.last, got.last); errors++;
        end
    endfunction
endclass

module tb_aging_keyed_result_cache;

    localparam int Slots = 16;

    // Codes outside the defined sets.
    localparam logic [1:0] CfgUnused    = 2'd3;
    localparam logic [2:0] FuncUnusedLo = 3'd5;
    localparam logic [2:0] FuncUnusedHi = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_func = '0;
    logic [7:0]  i_transport = '0;
    logic [11:0] i_discriminator = '0;
    logic [15:0] i_vendor_id = '0;
    logic [15:0] i_product_id = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_busy, o_valid, o_list_changed, o_entry_valid, o_last;
    logic [1:0]  o_status;
    logic [4:0]  o_entry_count;
    logic [7:0]  o_out_transport;
    logic [11:0] o_out_discriminator;
    logic [15:0] o_out_vendor_id, o_out_product_id;

    aging_keyed_result_cache u_top (.*);

    always #5 i_clk = ~i_clk;

    // Predicted table contents and registers.
    logic [15:0] ttl_load;
    logic [4:0]  cap;
    logic        live[Slots];
    logic [51:0] keys[Slots];
    logic [15:0] ttls[Slots];

    cache_scoreboard sb = new();
    int idle_pct;
    int n_items;
    int n_collect_words;

    function automatic int live_count();
        int n = 0;
        for (int i = 0; i < Slots; i++) if (live[i]) n++;
        return n;
    endfunction

    function automatic t_word plain_word(logic [1:0] st, logic ch);
        t_word w;
        w = '0;
        w.status = st;
        w.changed = ch;
        w.count = 5'(live_count());
        w.last = 1'b1;
        return w;
    endfunction

    // Work out the result words of one input and advance the predicted table.
    function automatic void predict_table(logic [2:0] fn, logic [7:0] tr, logic [11:0] dc,
                                          logic [15:0] vd, logic [15:0] pd);
        t_word ws[$];
        t_word w;
        logic [51:0] k;
        logic [51:0] sorted[$];
        logic [51:0] tmp;
        int fs;
        logic ch;
        k = {tr, dc, vd, pd};
        ch = 1'b0;
        fs = -1;
        case (fn)
            akrc_pkg::FUNC_REPORT: begin
                for (int i = 0; i < Slots; i++) begin
                    if (live[i] && keys[i] == k && fs == -1) begin
                        ttls[i] = ttl_load;
                        fs = -2;
                    end
                end
                if (fs == -2) begin
                    ws = {ws, plain_word(akrc_pkg::STAT_REFRESHED, 1'b0)};
                end else begin
                    for (int i = Slots - 1; i >= 0; i--) if (!live[i]) fs = i;
                    if (live_count() >= cap || fs < 0) begin
                        ws = {ws, plain_word(akrc_pkg::STAT_DROPPED, 1'b0)};
                    end else begin
                        live[fs] = 1'b1;
                        keys[fs] = k;
                        ttls[fs] = ttl_load;
                        ws = {ws, plain_word(akrc_pkg::STAT_INSERTED, 1'b1)};
                    end
                end
            end
            akrc_pkg::FUNC_TICK: begin
                for (int i = 0; i < Slots; i++) begin
                    if (live[i]) begin
                        if (ttls[i] <= 1) begin
                            live[i] = 1'b0;
                            ch = 1'b1;
                        end else begin
                            ttls[i] = ttls[i] - 16'd1;
                        end
                    end
                end
                ws = {ws, plain_word(akrc_pkg::STAT_OTHER, ch)};
            end
            akrc_pkg::FUNC_CLEAR_MSK: begin
                for (int i = 0; i < Slots; i++) begin
                    if (live[i] && (keys[i][51:44] & tr) != 0) begin
                        live[i] = 1'b0;
                        ch = 1'b1;
                    end
                end
                ws = {ws, plain_word(akrc_pkg::STAT_OTHER, ch)};
            end
            akrc_pkg::FUNC_COLLECT: begin
                for (int i = 0; i < Slots; i++) if (live[i]) sorted = {sorted, keys[i]};
                for (int a = 0; a < sorted.size(); a++) begin
                    for (int b = a + 1; b < sorted.size(); b++) begin
                        if (sorted[b] < sorted[a]) begin
                            tmp = sorted[a]; sorted[a] = sorted[b]; sorted[b] = tmp;
                        end
                    end
                end
                if (sorted.size() == 0) ws = {ws, plain_word(akrc_pkg::STAT_OTHER, 1'b0)};
                foreach (sorted[j]) begin
                    w = plain_word(akrc_pkg::STAT_OTHER, 1'b0);
                    w.ent_valid = 1'b1;
                    {w.tr, w.disc, w.vid, w.pid} = sorted[j];
                    w.last = (j == sorted.size() - 1);
                    ws = {ws, w};
                end
            end
            akrc_pkg::FUNC_CLEAR_ALL: begin
                for (int i = 0; i < Slots; i++) begin
                    if (live[i]) ch = 1'b1;
                    live[i] = 1'b0;
                end
                ws = {ws, plain_word(akrc_pkg::STAT_OTHER, ch)};
            end
            default: ws = {ws, plain_word(akrc_pkg::STAT_OTHER, 1'b0)};
        endcase
        sb.note_input(ws);
    endfunction

    // Result monitor: the receiver never stalls, every strobed word is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_word({o_status, o_list_changed, o_entry_count, o_entry_valid,
                           o_out_transport, o_out_discriminator, o_out_vendor_id,
                           o_out_product_id, o_last});
            if (o_entry_valid) n_collect_words++;
        end
    end

    // Present one word and hold it until the block takes it. Start stays high
    // after the edge that takes it; the next idle gap or drain lowers it.
    task automatic send_word(logic [2:0] fn, logic [7:0] tr, logic [11:0] dc,
                             logic [15:0] vd, logic [15:0] pd);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func <= fn;
        i_transport <= tr;
        i_discriminator <= dc;
        i_vendor_id <= vd;
        i_product_id <= pd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_table(fn, tr, dc, vd, pd);
        n_items++;
    endtask

    // Stop sending, wait for every expected word, then let the block settle.
    task automatic drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == akrc_pkg::CFG_TIMEOUT) ttl_load = val;
        else if (idx == akrc_pkg::CFG_MAX_CACHED) cap = val[4:0];
        @(posedge i_clk);
    endtask

    // Mostly reports from a small key pool so that refreshes and collisions occur.
    task automatic random_word();
        int r;
        logic [7:0] tr;
        logic [11:0] dc;
        r = $urandom_range(99);
        tr = 8'h1 << $urandom_range(7);
        dc = 12'($urandom_range(5));
        if (r < 8) tr = 8'($urandom);
        if (r < 55)
            send_word(akrc_pkg::FUNC_REPORT, tr, r < 8 ? 12'($urandom) : dc,
                      r < 8 ? 16'($urandom) : 16'hFFF0, 16'($urandom_range(3)));
        else if (r < 75) send_word(akrc_pkg::FUNC_TICK, 8'($urandom), '0, '0, '0);
        else if (r < 83) send_word(akrc_pkg::FUNC_CLEAR_MSK, 8'($urandom), '0, '0, '0);
        else if (r < 92) send_word(akrc_pkg::FUNC_COLLECT, '0, '0, '0, '0);
        else if (r < 95) send_word(akrc_pkg::FUNC_CLEAR_ALL, '0, '0, '0, '0);
        else send_word(3'($urandom_range(FuncUnusedHi, FuncUnusedLo)), 8'($urandom),
                       12'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        #20_000_000;
        $display("tb_aging_keyed_result_cache: errors");
        $finish;
    end

    initial begin
        int pct[4];
        pct = '{0, 67, 0, 28};
        ttl_load = akrc_pkg::TimeoutReset;
        cap = akrc_pkg::MaxCachedReset;
        foreach (live[i]) live[i] = 1'b0;
        idle_pct = 0;
        n_items = 0;
        n_collect_words = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of the key fields, every function, refresh and drops.
        send_word(akrc_pkg::FUNC_COLLECT, '0, '0, '0, '0);
        send_word(akrc_pkg::FUNC_CLEAR_ALL, '0, '0, '0, '0);
        send_word(akrc_pkg::FUNC_REPORT, 8'hFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
        send_word(akrc_pkg::FUNC_REPORT, 8'h00, 12'h000, 16'h0000, 16'h0000);
        send_word(akrc_pkg::FUNC_REPORT, 8'hFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 10; i++)
            send_word(akrc_pkg::FUNC_REPORT, 8'h02, 12'(i), 16'h1234, 16'h5678);
        send_word(akrc_pkg::FUNC_COLLECT, '0, '0, '0, '0);
        send_word(akrc_pkg::FUNC_CLEAR_MSK, 8'h02, '0, '0, '0);
        send_word(akrc_pkg::FUNC_TICK, '0, '0, '0, '0);
        send_word(FuncUnusedLo, 8'hAA, 12'h555, 16'hAAAA, 16'h5555);
        send_word(FuncUnusedHi, '0, '0, '0, '0);
        send_word(akrc_pkg::FUNC_CLEAR_ALL, '0, '0, '0, '0);
        drain();

        // Zero lifetime, cap beyond the slot count, cap of zero.
        write_reg(akrc_pkg::CFG_TIMEOUT, 16'd0);
        write_reg(akrc_pkg::CFG_MAX_CACHED, 16'd31);
        write_reg(CfgUnused, 16'hFFFF);
        for (int i = 0; i < 18; i++)
            send_word(akrc_pkg::FUNC_REPORT, 8'h80, 12'(i), '0, 16'(i));
        send_word(akrc_pkg::FUNC_COLLECT, '0, '0, '0, '0);
        send_word(akrc_pkg::FUNC_TICK, '0, '0, '0, '0);
        send_word(akrc_pkg::FUNC_TICK, '0, '0, '0, '0);
        drain();
        write_reg(akrc_pkg::CFG_MAX_CACHED, 16'd0);
        send_word(akrc_pkg::FUNC_REPORT, 8'h01, 12'h1, 16'h1, 16'h1);
        drain();

        // Random phases, each under its own settings and idling.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = pct[ph];
            write_reg(akrc_pkg::CFG_TIMEOUT,
                      ph == 2 ? 16'hFFFF : 16'($urandom_range(6, 1)));
            write_reg(akrc_pkg::CFG_MAX_CACHED,
                      ph == 1 ? 16'd16 : 16'($urandom_range(16, 1)));
            for (int j = 0; j < 90; j++) random_word();
            drain();
        end

        $display("Sent %0d words, checked %0d results, %0d collected entries.",
                 n_items, sb.checked, n_collect_words);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_aging_keyed_result_cache: clean");
        else
            $display("tb_aging_keyed_result_cache: errors");
        $finish;
    end
endmodule
